// File: rtl/core/toggle_switch_stochastic_step_assert.svh
// Assertion macros shared by the toggle switch RTL.
`ifndef TOGGLE_SWITCH_STOCHASTIC_STEP_ASSERT_SVH
`define TOGGLE_SWITCH_STOCHASTIC_STEP_ASSERT_SVH
`ifndef SYNTH
`define TSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define TSS_ASSERT_IMPL(lbl, ante, cons)
`define TSS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/tss_pkg.sv
// Constants, types and helpers of the toggle switch step block.
package tss_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned One      = 1 << FracBits;
  localparam int unsigned NoiseW   = 16;
  localparam int unsigned LevelW   = 32;
  localparam int unsigned AddrW    = 5;

  localparam logic [29:0] Ln2Q30    = 30'd744261118;
  localparam logic [24:0] DecayQ30  = 25'd32212255;
  localparam logic [63:0] PowSat    = 64'h4000_0000_0000_0000;
  localparam logic [31:0] LevelInit = 32'(10 * One);
  localparam logic [11:0] StepsInit = 12'd300;
  localparam logic [3:0]  TaylorTerms = 4'd12;

  // register map, index = paddr[4:2]
  localparam logic [2:0] RegObsOffset   = 3'd0;
  localparam logic [2:0] RegObsScale    = 3'd1;
  localparam logic [2:0] RegObsPower    = 3'd2;
  localparam logic [2:0] RegDriveFirst  = 3'd3;
  localparam logic [2:0] RegHillFirst   = 3'd4;
  localparam logic [2:0] RegDriveSecond = 3'd5;
  localparam logic [2:0] RegHillSecond  = 3'd6;
  localparam logic [2:0] RegSteps       = 3'd7;

  typedef struct packed {
    logic        start;
    logic [6:0]  iters;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  function automatic logic [31:0] clamp_level(input logic signed [49:0] v);
    if (v < $signed(50'(One))) begin
      return 32'(One);
    end else if (v > $signed(50'h0_FFFF_FFFF)) begin
      return 32'hFFFF_FFFF;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: rtl/core/tss_if.sv
// Stream interfaces for noise input and observation output.
interface tss_in_if;
  logic valid;
  logic ready;
  logic signed [tss_pkg::NoiseW-1:0] noise_first;
  logic signed [tss_pkg::NoiseW-1:0] noise_second;
  modport source (output valid, noise_first, noise_second, input ready);
  modport sink   (input valid, noise_first, noise_second, output ready);
endinterface

interface tss_out_if;
  logic valid;
  logic ready;
  logic [tss_pkg::LevelW-1:0] obs_first;
  logic [tss_pkg::LevelW-1:0] obs_second;
  modport source (output valid, obs_first, obs_second, input ready);
  modport sink   (input valid, obs_first, obs_second, output ready);
endinterface

// File: rtl/core/tss_div.sv
// Shared restoring divider, one quotient bit per cycle.
`include "toggle_switch_stochastic_step_assert.svh"
module tss_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tss_pkg::div_req_t  req_i,
  output tss_pkg::div_rsp_t  rsp_o
);
  import tss_pkg::*;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] quo_q, rem_q, dvs_q;
  logic [64:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q, quo_q[63]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      // left-align so only the significant dividend bits are iterated
      quo_q <= req_i.dividend << (7'd64 - req_i.iters);
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  `TSS_ASSERT_IMPL(a_done_not_busy, done_q, !busy_q)
  `TSS_ASSERT_NEXT(a_start_busy, req_i.start, busy_q)
  `TSS_ASSERT_IMPL(a_busy_count, busy_q, cnt_q != 7'd0)
endmodule

// File: rtl/core/toggle_switch_stochastic_step.sv
// Top level: two-gene toggle switch stochastic step with noisy observation.
//
// in_i carries two Q4.12 normal noise samples per transfer; out_o carries
// the two Q16.16 observed gene levels. Registers are written over the APB
// port (byte address 4*index, pready always high).
// Each input transfer is either a time step of the run or, once the run has
// reached steps_per_run-1 updates, the observation item that yields one
// output transfer and restarts the run at levels of 10.0.
// Per gene an item computes one power via log2 (16 squaring passes on the
// shared multiplier) and an exp2 series up to the twelfth power whose term
// divisions run on the shared bit-serial divider, then one more divide for
// the drive or observation term.
// in_i.ready is high only between items. A finished observation sits in
// an output register; if the receiver stalls, the block holds the result
// until out_o.ready and then takes the next item.
// Reset is asynchronous: levels return to 10.0, the step count to zero,
// steps_per_run to 300, the other control and config registers to zero.
`include "toggle_switch_stochastic_step_assert.svh"
module toggle_switch_stochastic_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  tss_in_if.sink                    in_i,
  tss_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tss_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import tss_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_POW_START = 5'd1;
  localparam logic [4:0] S_NORM      = 5'd2;
  localparam logic [4:0] S_LOG_MUL   = 5'd3;
  localparam logic [4:0] S_LOG_ACC   = 5'd4;
  localparam logic [4:0] S_E_MUL     = 5'd5;
  localparam logic [4:0] S_E_ACC     = 5'd6;
  localparam logic [4:0] S_X_MUL     = 5'd7;
  localparam logic [4:0] S_X_ACC     = 5'd8;
  localparam logic [4:0] S_T_MUL     = 5'd9;
  localparam logic [4:0] S_T_DIV     = 5'd10;
  localparam logic [4:0] S_T_WAIT    = 5'd11;
  localparam logic [4:0] S_POW_FIN   = 5'd12;
  localparam logic [4:0] S_D_DIV     = 5'd13;
  localparam logic [4:0] S_D_WAIT    = 5'd14;
  localparam logic [4:0] S_DEC_MUL   = 5'd15;
  localparam logic [4:0] S_UPD       = 5'd16;
  localparam logic [4:0] S_MS_MUL    = 5'd17;
  localparam logic [4:0] S_MS_ACC    = 5'd18;
  localparam logic [4:0] S_MM_MUL    = 5'd19;
  localparam logic [4:0] S_O_DIV     = 5'd20;
  localparam logic [4:0] S_O_WAIT    = 5'd21;
  localparam logic [4:0] S_OBS       = 5'd22;
  localparam logic [4:0] S_DONE      = 5'd23;

  localparam logic [7:0] ExpBias = 8'(30 - FracBits);

  // configuration
  logic [25:0] obs_offset_q;
  logic [19:0] obs_scale_q;
  logic [18:0] obs_power_q;
  logic [22:0] drive_first_q, drive_second_q;
  logic [19:0] hill_first_q, hill_second_q;
  logic [11:0] steps_q;

  // control state
  logic [4:0]  state_q, state_d;
  logic [31:0] level_first_q, level_second_q;
  logic [11:0] step_count_q;
  logic        out_valid_q;
  logic        gene_q, obs_q;

  // datapath
  logic signed [15:0] nz_first_q, nz_second_q;
  logic [31:0] nx_q, m_q, sum_q, res0_q, res1_q;
  logic [4:0]  k_q;
  logic [3:0]  i_q, n_q;
  logic [15:0] frac_q, ef_q;
  logic [7:0]  ei_q;
  logic [29:0] x_q, ms_q;
  logic [30:0] term_q;
  logic [63:0] pw_q;
  logic [23:0] d_q;
  logic [33:0] t_q;
  logic [31:0] obs_first_q, obs_second_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, mul_q;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        accept, cfg_wr, obs_item, out_load;
  logic [2:0]  cfg_idx;
  logic [31:0] lvl_self, lvl_other, pow_base, sq;
  logic [19:0] pow_expo, log_val;
  logic [22:0] drive_sel;
  logic signed [15:0] noise_sel;
  logic [15:0] mag;
  logic [4:0]  kdiff;
  logic [7:0]  amt;
  logic [63:0] pw_calc, pw_sh;
  logic signed [49:0] noise_ext, half, v_upd, v_obs, base_obs, t_ext;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      RegObsOffset:   prdata = {6'b0, obs_offset_q};
      RegObsScale:    prdata = {12'b0, obs_scale_q};
      RegObsPower:    prdata = {13'b0, obs_power_q};
      RegDriveFirst:  prdata = {9'b0, drive_first_q};
      RegHillFirst:   prdata = {12'b0, hill_first_q};
      RegDriveSecond: prdata = {9'b0, drive_second_q};
      RegHillSecond:  prdata = {12'b0, hill_second_q};
      RegSteps:       prdata = {20'b0, steps_q};
      default:        prdata = '0;
    endcase
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign accept       = in_i.valid && in_i.ready;
  assign obs_item     = ({1'b0, step_count_q} + 13'd1) >= {1'b0, steps_q};
  assign out_load     = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign out_o.valid      = out_valid_q;
  assign out_o.obs_first  = obs_first_q;
  assign out_o.obs_second = obs_second_q;

  // per-gene operand selection
  assign lvl_self  = gene_q ? level_second_q : level_first_q;
  assign lvl_other = gene_q ? level_first_q : level_second_q;
  assign drive_sel = gene_q ? drive_second_q : drive_first_q;
  assign noise_sel = gene_q ? nz_second_q : nz_first_q;
  assign pow_base  = obs_q ? lvl_self : lvl_other;
  assign pow_expo  = obs_q ? {1'b0, obs_power_q} : (gene_q ? hill_second_q : hill_first_q);
  assign mag       = noise_sel[15] ? 16'(~noise_sel + 16'sd1) : 16'(noise_sel);
  assign kdiff     = k_q - 5'(FracBits);
  assign log_val   = {kdiff[3:0], frac_q};
  assign sq        = mul_q[61:30];

  // shared multiplier, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_LOG_MUL: begin mul_a = m_q;                      mul_b = m_q; end
      S_E_MUL:   begin mul_a = {12'b0, pow_expo};        mul_b = {12'b0, log_val}; end
      S_X_MUL:   begin mul_a = {2'b0, ef_q, 14'b0};      mul_b = {2'b0, Ln2Q30}; end
      S_T_MUL:   begin mul_a = {1'b0, term_q};           mul_b = {2'b0, x_q}; end
      S_DEC_MUL: begin mul_a = lvl_self;                 mul_b = {7'b0, DecayQ30}; end
      S_MS_MUL:  begin mul_a = {6'b0, obs_offset_q};     mul_b = {12'b0, obs_scale_q}; end
      S_MM_MUL:  begin mul_a = {2'b0, ms_q};             mul_b = {16'b0, mag}; end
      default:   begin mul_a = '0;                       mul_b = '0; end
    endcase
  end
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    div_req = '0;
    case (state_q)
      S_T_DIV: begin
        div_req.start    = 1'b1;
        div_req.iters    = 7'd32;
        div_req.dividend = {33'b0, mul_q[60:30]};
        div_req.divisor  = {60'b0, n_q};
      end
      S_D_DIV: begin
        div_req.start    = 1'b1;
        div_req.iters    = 7'd40;
        div_req.dividend = {25'b0, drive_sel, 16'b0};
        div_req.divisor  = 64'(One) + pw_q;
      end
      S_O_DIV: begin
        div_req.start    = 1'b1;
        div_req.iters    = 7'd64;
        div_req.dividend = {mul_q[47:0], 16'b0};
        div_req.divisor  = pw_q;
      end
      default: div_req = '0;
    endcase
  end

  tss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // scale the series sum by the integer part of the exponent
  always_comb begin
    amt     = ei_q - ExpBias;
    pw_sh   = {32'b0, sum_q} << amt[5:0];
    pw_calc = PowSat;
    if (ei_q > 8'd61) begin
      pw_calc = PowSat;
    end else if (ei_q < ExpBias) begin
      pw_calc = {32'b0, sum_q} >> (ExpBias - ei_q);
    end else if (amt > 8'd31) begin
      pw_calc = PowSat;
    end else if (pw_sh > PowSat) begin
      pw_calc = PowSat;
    end else begin
      pw_calc = pw_sh;
    end
  end

  assign noise_ext = {{34{noise_sel[15]}}, noise_sel};
  assign half      = (noise_ext <<< (FracBits - 12)) >>> 1;
  assign v_upd     = $signed({18'b0, lvl_self}) + $signed({26'b0, d_q})
                   - $signed(50'(One)) - $signed({18'b0, mul_q[61:30]}) + half;
  assign base_obs  = $signed({18'b0, lvl_self}) + $signed({24'b0, obs_offset_q});
  assign t_ext     = $signed({16'b0, t_q});
  assign v_obs     = noise_sel[15] ? base_obs - t_ext : base_obs + t_ext;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (accept) state_d = S_POW_START;
      S_POW_START: state_d = S_NORM;
      S_NORM:      if (nx_q[31]) state_d = S_LOG_MUL;
      S_LOG_MUL:   state_d = S_LOG_ACC;
      S_LOG_ACC:   state_d = (i_q == 4'(FracBits - 1)) ? S_E_MUL : S_LOG_MUL;
      S_E_MUL:     state_d = S_E_ACC;
      S_E_ACC:     state_d = S_X_MUL;
      S_X_MUL:     state_d = S_X_ACC;
      S_X_ACC:     state_d = S_T_MUL;
      S_T_MUL:     state_d = S_T_DIV;
      S_T_DIV:     state_d = S_T_WAIT;
      S_T_WAIT: begin
        if (div_rsp.done) state_d = (n_q == TaylorTerms) ? S_POW_FIN : S_T_MUL;
      end
      S_POW_FIN:   state_d = obs_q ? S_MS_MUL : S_D_DIV;
      S_D_DIV:     state_d = S_D_WAIT;
      S_D_WAIT:    if (div_rsp.done) state_d = S_DEC_MUL;
      S_DEC_MUL:   state_d = S_UPD;
      S_UPD:       state_d = gene_q ? S_IDLE : S_POW_START;
      S_MS_MUL:    state_d = S_MS_ACC;
      S_MS_ACC:    state_d = S_MM_MUL;
      S_MM_MUL:    state_d = S_O_DIV;
      S_O_DIV:     state_d = S_O_WAIT;
      S_O_WAIT:    if (div_rsp.done) state_d = S_OBS;
      S_OBS:       state_d = gene_q ? S_DONE : S_POW_START;
      S_DONE:      if (out_load) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      level_first_q  <= LevelInit;
      level_second_q <= LevelInit;
      step_count_q   <= '0;
      out_valid_q    <= 1'b0;
      gene_q         <= 1'b0;
      obs_q          <= 1'b0;
      obs_offset_q   <= '0;
      obs_scale_q    <= '0;
      obs_power_q    <= '0;
      drive_first_q  <= '0;
      hill_first_q   <= '0;
      drive_second_q <= '0;
      hill_second_q  <= '0;
      steps_q        <= StepsInit;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && !out_o.ready) || out_load;
      if (cfg_wr) begin
        case (cfg_idx)
          RegObsOffset:   obs_offset_q   <= pwdata[25:0];
          RegObsScale:    obs_scale_q    <= pwdata[19:0];
          RegObsPower:    obs_power_q    <= pwdata[18:0];
          RegDriveFirst:  drive_first_q  <= pwdata[22:0];
          RegHillFirst:   hill_first_q   <= pwdata[19:0];
          RegDriveSecond: drive_second_q <= pwdata[22:0];
          RegHillSecond:  hill_second_q  <= pwdata[19:0];
          RegSteps:       steps_q        <= pwdata[11:0];
          default:        steps_q        <= steps_q;
        endcase
      end
      if (accept) begin
        obs_q  <= obs_item;
        gene_q <= 1'b0;
      end
      if (state_q == S_UPD) begin
        gene_q <= 1'b1;
        if (gene_q) begin
          level_first_q  <= res0_q;
          level_second_q <= clamp_level(v_upd);
          step_count_q   <= step_count_q + 12'd1;
        end
      end
      if (state_q == S_OBS) begin
        gene_q <= 1'b1;
        if (gene_q) begin
          // run restarts once both observations are captured
          level_first_q  <= LevelInit;
          level_second_q <= LevelInit;
          step_count_q   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          nz_first_q  <= in_i.noise_first;
          nz_second_q <= in_i.noise_second;
        end
      end
      S_POW_START: begin
        nx_q <= pow_base;
        k_q  <= 5'd31;
      end
      S_NORM: begin
        if (nx_q[31]) begin
          m_q    <= {1'b0, nx_q[31:1]};
          i_q    <= '0;
          frac_q <= '0;
        end else begin
          nx_q <= {nx_q[30:0], 1'b0};
          k_q  <= k_q - 5'd1;
        end
      end
      S_LOG_ACC: begin
        frac_q <= {frac_q[14:0], sq[31]};
        m_q    <= sq[31] ? {1'b0, sq[31:1]} : sq;
        i_q    <= i_q + 4'd1;
      end
      S_E_ACC: begin
        ei_q <= mul_q[39:32];
        ef_q <= mul_q[31:16];
      end
      S_X_ACC: begin
        x_q    <= mul_q[59:30];
        term_q <= 31'h4000_0000;
        sum_q  <= 32'h4000_0000;
        n_q    <= 4'd1;
      end
      S_T_WAIT: begin
        if (div_rsp.done) begin
          term_q <= div_rsp.quot[30:0];
          sum_q  <= sum_q + {1'b0, div_rsp.quot[30:0]};
          n_q    <= n_q + 4'd1;
        end
      end
      S_POW_FIN: pw_q <= pw_calc;
      S_D_WAIT:  if (div_rsp.done) d_q <= div_rsp.quot[23:0];
      S_UPD:     if (!gene_q) res0_q <= clamp_level(v_upd);
      S_MS_ACC:  ms_q <= mul_q[45:16];
      S_O_WAIT:  if (div_rsp.done) t_q <= div_rsp.quot[45:12];
      S_OBS: begin
        if (gene_q) res1_q <= clamp_level(v_obs);
        else        res0_q <= clamp_level(v_obs);
      end
      S_DONE: begin
        if (out_load) begin
          obs_first_q  <= res0_q;
          obs_second_q <= res1_q;
        end
      end
      default: ;
    endcase
  end

  `TSS_ASSERT_IMPL(a_ready_div_idle, in_i.ready, !div_rsp.busy)
  `TSS_ASSERT_NEXT(a_accept_blocks, accept, !in_i.ready)
  `TSS_ASSERT_IMPL(a_levels_floor, 1'b1, level_first_q >= 32'(One) && level_second_q >= 32'(One))
  `TSS_ASSERT_IMPL(a_done_in_wait, div_rsp.done,
                   state_q == S_T_WAIT || state_q == S_D_WAIT || state_q == S_O_WAIT)
endmodule
